// File: rtl/core/kapb_pkg.sv
// ----------------------------------------------------------------------------
// kapb_pkg
// Shared widths, codes, state type and controller/datapath bundles for the
// keyframe-aligned pre-roll buffer.
// ----------------------------------------------------------------------------
package kapb_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int DEFAULT_TAG_W = 16;

    localparam int TS_W       = 32;
    localparam int STATUS_W   = 2;
    localparam int DROP_W     = 10;
    localparam int OCC_W      = 11;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJ_KEY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJ_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRIM_DONE = 2'd3;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TRIM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENFORCE = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TRIM,
        S_SCAN,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic                latch;
        logic                append;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                start_scan;
        logic                issue;
        logic                commit;
        logic                out_load;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_trim;
        logic first_key;
        logic enforce;
        logic empty;
        logic full;
        logic trim_skip;
        logic chk_valid;
        logic chk_hit;
        logic chk_block;
        logic scan_more;
    } t_dp_status;

endpackage

// File: rtl/core/keyframe_aligned_preroll_buffer_core.sv
// Scan: a rejected packet skips it; an accepted add or a trim may start one, which
// reads the held entries newest first, pipelined through the registered read
// port, and stops at the first qualifying keyframe.
// Throughput: one item at a time; the next input is taken only after the result
// enters the output register, which may still be waiting on the consumer.
// Reset: buffer empty, window 0, keyframe enforcement on; no RAM clearing pass.
// ----------------------------------------------------------------------------
// keyframe_aligned_preroll_buffer_core
// Ring of packet descriptors trimmed from the front to a video keyframe at or
// before the newest timestamp minus the window duration.
// ----------------------------------------------------------------------------
module keyframe_aligned_preroll_buffer_core
    import kapb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
    parameter int TAG_WIDTH    = DEFAULT_TAG_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [TS_W-1:0]       i_timestamp,
    input  logic                  i_is_video,
    input  logic                  i_is_key,
    input  logic [TAG_WIDTH-1:0]  i_packet_tag,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DROP_W-1:0]     o_dropped_count,
    output logic [OCC_W-1:0]      o_occupancy,
    output logic [TAG_WIDTH-1:0]  o_oldest_tag,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status dp;

    assign o_cfg_ready = 1'b1;

    kapb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_dp        (dp),
        .o_cmd       (cmd)
    );

    kapb_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .TAG_WIDTH    (TAG_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_command),
        .i_timestamp     (i_timestamp),
        .i_is_video      (i_is_video),
        .i_is_key        (i_is_key),
        .i_packet_tag    (i_packet_tag),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_dp            (dp),
        .o_status        (o_status),
        .o_dropped_count (o_dropped_count),
        .o_occupancy     (o_occupancy),
        .o_oldest_tag    (o_oldest_tag)
    );

endmodule

// File: rtl/core/kapb_ram.sv
// ----------------------------------------------------------------------------
// kapb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kapb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/kapb_ctrl.sv
// ----------------------------------------------------------------------------
// kapb_ctrl
// Sequencer: input acceptance, add/reject decision, backward keyframe scan
// and result hand-off into the output register.
// ----------------------------------------------------------------------------
module kapb_ctrl
    import kapb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_dp,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.set_status = 1'b1;
                if (i_dp.is_trim) begin
                    o_cmd.status = ST_TRIM_DONE;
                    n_state      = S_TRIM;
                end else if (i_dp.enforce && i_dp.empty && !i_dp.first_key) begin
                    o_cmd.status = ST_REJ_KEY;
                    n_state      = S_DONE;
                end else if (i_dp.full) begin
                    o_cmd.status = ST_REJ_FULL;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.status = ST_ACCEPTED;
                    o_cmd.append = 1'b1;
                    n_state      = S_TRIM;
                end
            end
            S_TRIM: begin
                o_cmd.start_scan = 1'b1;
                n_state = i_dp.trim_skip ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (i_dp.chk_valid && i_dp.chk_hit) begin
                    // stop at the newest qualifying keyframe
                    o_cmd.commit = !i_dp.chk_block;
                    n_state      = S_DONE;
                end else if (i_dp.scan_more) begin
                    o_cmd.issue = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/kapb_dpath.sv
// ----------------------------------------------------------------------------
// kapb_dpath
// Ring pointers, configuration registers, descriptor RAM, scan pipeline and
// result register.
// ----------------------------------------------------------------------------
module kapb_dpath
    import kapb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
    parameter int TAG_WIDTH    = DEFAULT_TAG_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_command,
    input  logic [TS_W-1:0]       i_timestamp,
    input  logic                  i_is_video,
    input  logic                  i_is_key,
    input  logic [TAG_WIDTH-1:0]  i_packet_tag,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_dp,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DROP_W-1:0]     o_dropped_count,
    output logic [OCC_W-1:0]      o_occupancy,
    output logic [TAG_WIDTH-1:0]  o_oldest_tag
);

    localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW = TS_W + 2 + TAG_WIDTH;
    localparam logic [PW:0]   DEPTH_P = (PW + 1)'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    // latched input item
    logic                 r_cmd;
    logic [TS_W-1:0]      r_ts;
    logic                 r_vid;
    logic                 r_key;
    logic [TAG_WIDTH-1:0] r_tag;

    logic [WIN_W-1:0]     r_window;
    logic                 r_enforce;

    logic [PW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [TS_W-1:0]      r_newest;
    logic [TAG_WIDTH-1:0] r_head_tag;
    logic [TS_W-1:0]      r_limit;
    logic [PW-1:0]        r_scan_idx;
    logic                 r_chk_valid;
    logic [PW-1:0]        r_chk_idx;
    logic [DROP_W-1:0]    r_dropped;
    logic [STATUS_W-1:0]  r_status;

    logic [STATUS_W-1:0]  r_o_status;
    logic [DROP_W-1:0]    r_o_dropped;
    logic [OCC_W-1:0]     r_o_occ;
    logic [TAG_WIDTH-1:0] r_o_tag;

    logic [EW-1:0]        rd_data;
    logic [TS_W-1:0]      rd_ts;
    logic                 rd_vid;
    logic                 rd_key;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [PW-1:0]        wr_addr;
    logic [PW-1:0]        rd_addr;

    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_P) begin
            sum = sum - DEPTH_P;
        end
        return sum[PW-1:0];
    endfunction

    assign wr_addr = f_slot(r_head, r_count[PW-1:0]);
    assign rd_addr = f_slot(r_head, r_scan_idx);

    kapb_ram #(
        .WIDTH (EW),
        .DEPTH (BUFFER_DEPTH),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (wr_addr),
        .i_wdata ({r_ts, r_vid, r_key, r_tag}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_ts  = rd_data[EW-1 -: TS_W];
    assign rd_vid = rd_data[TAG_WIDTH + 1];
    assign rd_key = rd_data[TAG_WIDTH];
    assign rd_tag = rd_data[TAG_WIDTH-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_enforce   <= 1'b1;
            r_head      <= '0;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_WINDOW) begin
                r_window <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_ENFORCE) begin
                r_enforce <= i_cfg_data[0];
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.start_scan) begin
                r_chk_valid <= 1'b0;
            end
            if (i_cmd.issue) begin
                r_chk_valid <= 1'b1;
            end
            if (i_cmd.commit) begin
                // advance the front to the keyframe found
                r_head  <= f_slot(r_head, r_chk_idx);
                r_count <= r_count - CW'(r_chk_idx);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd     <= i_command;
            r_ts      <= i_timestamp;
            r_vid     <= i_is_video;
            r_key     <= i_is_key;
            r_tag     <= i_packet_tag;
            r_dropped <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.append) begin
            r_newest <= r_ts;
            if (r_count == '0) begin
                r_head_tag <= r_tag;
            end
        end
        if (i_cmd.start_scan) begin
            r_limit    <= r_newest - TS_W'(r_window);
            r_scan_idx <= PW'(r_count - CW'(1));
        end
        if (i_cmd.issue) begin
            r_chk_idx  <= r_scan_idx;
            r_scan_idx <= r_scan_idx - PW'(1);
        end
        if (i_cmd.commit) begin
            r_head_tag <= rd_tag;
            r_dropped  <= DROP_W'(r_chk_idx);
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_dropped <= r_dropped;
            r_o_occ     <= OCC_W'(r_count);
            r_o_tag     <= (r_count == '0) ? '0 : r_head_tag;
        end
    end

    always_comb begin
        o_dp.is_trim   = (r_cmd == CMD_TRIM);
        o_dp.first_key = r_vid && r_key;
        o_dp.enforce   = r_enforce;
        o_dp.empty     = (r_count == '0);
        o_dp.full      = (r_count == DEPTH_C);
        o_dp.trim_skip = (r_count == '0) || (r_newest < TS_W'(r_window));
        o_dp.chk_valid = r_chk_valid;
        o_dp.chk_hit   = rd_vid && rd_key && (rd_ts <= r_limit);
        o_dp.chk_block = !r_enforce && (r_chk_idx == PW'(1));
        o_dp.scan_more = (r_scan_idx != '0);
    end

    assign o_status        = r_o_status;
    assign o_dropped_count = r_o_dropped;
    assign o_occupancy     = r_o_occ;
    assign o_oldest_tag    = r_o_tag;

endmodule

// File: rtl/core/kapb_checker.sv
// ----------------------------------------------------------------------------
// kapb_checker
// Port-level checks for the pre-roll buffer, bound to the top level.
// ----------------------------------------------------------------------------
module kapb_checker
    import kapb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
    parameter int TAG_WIDTH    = DEFAULT_TAG_W
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [STATUS_W-1:0]  o_status,
    input logic [DROP_W-1:0]    o_dropped_count,
    input logic [OCC_W-1:0]     o_occupancy,
    input logic [TAG_WIDTH-1:0] o_oldest_tag
);

    // one item in flight: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous item still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_status, o_dropped_count, o_occupancy, o_oldest_tag}))
        else $error("stalled result changed");

    a_reject_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_REJ_KEY || o_status == ST_REJ_FULL)
            |-> o_dropped_count == '0)
        else $error("rejected packet reports dropped entries");

    a_empty_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_occupancy == '0 |-> o_oldest_tag == '0)
        else $error("empty buffer reports a front tag");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_REJ_FULL |-> o_occupancy == OCC_W'(BUFFER_DEPTH))
        else $error("full reject with buffer not full");

endmodule

bind keyframe_aligned_preroll_buffer_core kapb_checker #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .TAG_WIDTH    (TAG_WIDTH)
) u_kapb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_dropped_count (o_dropped_count),
    .o_occupancy     (o_occupancy),
    .o_oldest_tag    (o_oldest_tag)
);
